// ===== design/lpht_pkg.sv =====
`timescale 1ns / 1ps
package lpht_pkg;

	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int HASH_W      = 32;
	localparam int DEFAULT_CAP = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 8'd0,
		REG_SET_MODE = 8'd1
	} reg_idx_t;

	typedef enum logic {
		FUNC_PUT    = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] key;
		logic [31:0] key_hash;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] found_value;
		logic [9:0]  slot_index;
		logic [10:0] entry_count;
	} rsp_t;

endpackage

// ===== design/linear_probe_hash_table_core.sv =====
// Channel   | Signals                                  | Transfer
// ----------+------------------------------------------+-------------------------------
// request   | start, busy, req                         | start && !busy at clk rise
// result    | done, result                             | done high for one cycle
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// A request first finds the hash remainder (one quotient bit a cycle), then probes slots;
// each probe is one read of the table RAM, which has one read and one write port.
// An insert that grows the table clears the new bank, reads each old slot and runs
// another remainder plus probe run per live entry, then re-probes the key.
// After reset, and after a capacity write, the bank in use is cleared up to the table size
// while busy is high. Results cannot be stalled; done marks each one for one cycle.
`timescale 1ns / 1ps
module linear_probe_hash_table_core
	import lpht_pkg::*;
#(
	parameter int MAX_SLOTS  = 1024,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	input  req_t                  req,
	output logic                  busy,
	output logic                  done,
	output rsp_t                  result
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int SZ_W   = $clog2(MAX_SLOTS + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int DEPTH  = 2 * MAX_SLOTS;

	// One RAM holds two banks; growth rehashes from the old bank into the other.
	typedef struct packed {
		logic                  used;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] val;
		logic [HASH_W-1:0]     hash;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV, S_PRD, S_PCMP, S_CRD, S_CCHK
	} state_t;

	typedef enum logic [1:0] {
		M_REQ, M_REHASH, M_REPROBE
	} mode_t;

	function automatic logic [SZ_W-1:0] clamp_cap(input logic [CFG_DATA_W-1:0] v);
		logic [SZ_W-1:0] r;
		if (v == '0) begin
			r = SZ_W'(1);
		end else if (32'(v) > MAX_SLOTS) begin
			r = SZ_W'(MAX_SLOTS);
		end else begin
			r = SZ_W'(v);
		end
		return r;
	endfunction

	entry_t mem [DEPTH];
	entry_t rd_q;
	logic   we;
	logic [ADDR_W-1:0] raddr, waddr;
	entry_t wdata;

	state_t state_q;
	mode_t  mode_q;
	logic   bank_q;
	logic   set_mode_q;
	logic   clr_next_q;
	logic   done_q;
	rsp_t   res_q;
	req_t   req_q;
	logic [SZ_W-1:0]       size_q, old_size_q, cnt_q, clr_idx_q, copy_i_q, n_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SZ_W-1:0]       rem_q;
	logic [4:0]            div_bit_q;
	logic [KEY_BITS-1:0]   cur_key_q;
	logic [VALUE_BITS-1:0] cur_val_q;
	logic [HASH_W-1:0]     cur_hash_q;

	// remainder step, probe decode, growth math
	logic [SZ_W:0]   rem_sh, rem_nxt, sum;
	logic [SZ_W-1:0] cnt_new, free_slots, need, step, grown_size;
	logic [IDX_W-1:0] idx_nxt;
	logic slot_empty, key_eq, last, resolved, hit_any, grow, copy_last;

	always_comb begin
		rem_sh  = {rem_q, cur_hash_q[div_bit_q]};
		rem_nxt = (rem_sh >= {1'b0, size_q}) ? rem_sh - {1'b0, size_q} : rem_sh;

		slot_empty = !rd_q.used;
		key_eq     = rd_q.key == cur_key_q;
		last       = (n_q + SZ_W'(1)) == size_q;
		resolved   = slot_empty || key_eq || last;
		hit_any    = slot_empty || key_eq;
		idx_nxt    = ((SZ_W'(idx_q) + SZ_W'(1)) == size_q) ? '0 : idx_q + IDX_W'(1);

		cnt_new    = cnt_q + SZ_W'(1);
		free_slots = size_q - cnt_new;
		need       = ((size_q >> 2) == '0) ? SZ_W'(1) : (size_q >> 2);
		grow       = (free_slots < need) && (size_q != SZ_W'(MAX_SLOTS));
		step       = (size_q > SZ_W'(2)) ? size_q : SZ_W'(2);
		sum        = {1'b0, size_q} + {1'b0, step};
		grown_size = (sum > (SZ_W + 1)'(MAX_SLOTS)) ? SZ_W'(MAX_SLOTS) : sum[SZ_W-1:0];
		copy_last  = (copy_i_q + SZ_W'(1)) == old_size_q;
	end

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = {bank_q, idx_q};
		wdata = '{used: 1'b1, key: cur_key_q, val: cur_val_q, hash: cur_hash_q};
		raddr = (state_q == S_PRD) ? {bank_q, idx_q} : {~bank_q, copy_i_q[IDX_W-1:0]};
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = {bank_q, clr_idx_q[IDX_W-1:0]};
			wdata = '0;
		end else if (state_q == S_PCMP && resolved && hit_any) begin
			if (mode_q == M_REHASH) begin
				we = 1'b1;
			end else if (mode_q == M_REQ && req_q.func == FUNC_PUT) begin
				if (slot_empty) begin
					we = 1'b1;
				end else begin
					we         = !set_mode_q;
					wdata.hash = rd_q.hash;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			mode_q     <= M_REQ;
			bank_q     <= 1'b0;
			set_mode_q <= 1'b0;
			clr_next_q <= 1'b0;
			clr_idx_q  <= '0;
			size_q     <= clamp_cap(CFG_DATA_W'(DEFAULT_CAP));
			old_size_q <= '0;
			cnt_q      <= '0;
			copy_i_q   <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			rem_q      <= '0;
			div_bit_q  <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
			req_q      <= '0;
			cur_key_q  <= '0;
			cur_val_q  <= '0;
			cur_hash_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + SZ_W'(1);
					if ((clr_idx_q + SZ_W'(1)) == size_q) begin
						copy_i_q <= '0;
						state_q  <= clr_next_q ? S_CRD : S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q      <= req;
						cur_key_q  <= KEY_BITS'(req.key);
						cur_val_q  <= VALUE_BITS'(req.value);
						cur_hash_q <= req.key_hash;
						rem_q      <= '0;
						div_bit_q  <= 5'd31;
						mode_q     <= M_REQ;
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= rem_nxt[SZ_W-1:0];
					div_bit_q <= div_bit_q - 5'd1;
					if (div_bit_q == '0) begin
						idx_q   <= IDX_W'(rem_nxt);
						n_q     <= '0;
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					if (!resolved) begin
						idx_q   <= idx_nxt;
						n_q     <= n_q + SZ_W'(1);
						state_q <= S_PRD;
					end else begin
						unique case (mode_q)
							M_REHASH: begin
								// advance to the next old slot, or re-probe the new key
								copy_i_q <= copy_i_q + SZ_W'(1);
								state_q  <= S_CRD;
								if (copy_last) begin
									cur_key_q  <= KEY_BITS'(req_q.key);
									cur_val_q  <= VALUE_BITS'(req_q.value);
									cur_hash_q <= req_q.key_hash;
									rem_q      <= '0;
									div_bit_q  <= 5'd31;
									mode_q     <= M_REPROBE;
									state_q    <= S_DIV;
								end
							end
							M_REPROBE: begin
								res_q   <= '{ST_INSERTED, 32'd0, 10'(idx_q), 11'(cnt_q)};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								if (req_q.func == FUNC_LOOKUP) begin
									if (hit_any && !slot_empty) begin
										res_q <= '{ST_FOUND, 32'(rd_q.val), 10'(idx_q),
											11'(cnt_q)};
									end else begin
										res_q <= '{ST_MISSING, 32'd0, 10'd0, 11'(cnt_q)};
									end
								end else if (!hit_any) begin
									res_q <= '{ST_FULL, 32'd0, 10'd0, 11'(cnt_q)};
								end else if (!slot_empty) begin
									res_q <= '{ST_UPDATED, 32'd0, 10'(idx_q), 11'(cnt_q)};
								end else begin
									cnt_q <= cnt_new;
									res_q <= '{ST_INSERTED, 32'd0, 10'(idx_q), 11'(cnt_new)};
									if (grow) begin
										// hold the result; clear the other bank and rehash
										done_q     <= 1'b0;
										old_size_q <= size_q;
										size_q     <= grown_size;
										bank_q     <= ~bank_q;
										clr_idx_q  <= '0;
										clr_next_q <= 1'b1;
										state_q    <= S_CLEAR;
									end
								end
							end
						endcase
					end
				end
				S_CRD: begin
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					if (rd_q.used) begin
						cur_key_q  <= rd_q.key;
						cur_val_q  <= rd_q.val;
						cur_hash_q <= rd_q.hash;
						rem_q      <= '0;
						div_bit_q  <= 5'd31;
						mode_q     <= M_REHASH;
						state_q    <= S_DIV;
					end else if (copy_last) begin
						cur_key_q  <= KEY_BITS'(req_q.key);
						cur_val_q  <= VALUE_BITS'(req_q.value);
						cur_hash_q <= req_q.key_hash;
						rem_q      <= '0;
						div_bit_q  <= 5'd31;
						mode_q     <= M_REPROBE;
						state_q    <= S_DIV;
					end else begin
						copy_i_q <= copy_i_q + SZ_W'(1);
						state_q  <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// configuration transfer; a capacity write empties the table
			if (cfg_valid) begin
				if (cfg_index == REG_CAPACITY) begin
					size_q     <= clamp_cap(cfg_data);
					cnt_q      <= '0;
					clr_idx_q  <= '0;
					clr_next_q <= 1'b0;
					state_q    <= S_CLEAR;
				end else if (cfg_index == REG_SET_MODE) begin
					set_mode_q <= cfg_data[0];
				end
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign result    = res_q;

endmodule

// ===== design/lpht_checker.sv =====
`timescale 1ns / 1ps
module lpht_checker
	import lpht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_FULL)
		else $error("status code out of range");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_MISSING || result.status == ST_FULL)
		|-> result.found_value == 32'd0 && result.slot_index == 10'd0)
		else $error("miss or full result carries data");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for linear_probe_hash_table_core.
// The process driving requests predicts each result when its request transfers
// and queues it. A separate process pops one prediction per done pulse and
// compares it field by field.
module tb_top;
	import lpht_pkg::*;

	localparam int SLOTS = 1024;
	// Index past the last register: the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	req_t                  req = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  result;

	int   mismatches = 0;
	bit   no_gaps = 1'b0;
	rsp_t pending_rsp[$];

	// Predicted table contents and configuration.
	bit              tbl_used[SLOTS];
	logic [31:0]     tbl_key[SLOTS];
	logic [31:0]     tbl_val[SLOTS];
	logic [31:0]     tbl_hash[SLOTS];
	bit              prev_used[SLOTS];
	logic [31:0]     prev_key[SLOTS];
	logic [31:0]     prev_val[SLOTS];
	logic [31:0]     prev_hash[SLOTS];
	int unsigned     tbl_size;
	int unsigned     tbl_count;
	int unsigned     cap_reg;
	bit              keep_existing;

	// Random traffic draws keys from this pool so that puts and lookups collide.
	logic [31:0] key_pool[64];
	logic [31:0] hash_pool[64];

	always #5 clk = ~clk;

	linear_probe_hash_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic void clear_table();
		for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
		tbl_count = 0;
		if (cap_reg == 0) tbl_size = 1;
		else if (cap_reg > SLOTS) tbl_size = SLOTS;
		else tbl_size = cap_reg;
	endfunction

	// 1: key matched, 0: unused slot reached, -1: walked the whole table.
	function automatic int walk_chain(input logic [31:0] k, input logic [31:0] h,
			output int unsigned at);
		int unsigned idx;
		idx = h % tbl_size;
		at = 0;
		for (int unsigned n = 0; n < tbl_size; n++) begin
			if (!tbl_used[idx]) begin
				at = idx;
				return 0;
			end
			if (tbl_key[idx] == k) begin
				at = idx;
				return 1;
			end
			idx = (idx + 1 >= tbl_size) ? 0 : idx + 1;
		end
		return -1;
	endfunction

	function automatic void grow_table();
		int unsigned old_size;
		int unsigned grown_size;
		int unsigned at;
		old_size = tbl_size;
		if (old_size >= SLOTS) return;
		grown_size = old_size + ((old_size > 2) ? old_size : 2);
		if (grown_size > SLOTS) grown_size = SLOTS;
		for (int i = 0; i < SLOTS; i++) begin
			prev_used[i] = tbl_used[i];
			prev_key[i]  = tbl_key[i];
			prev_val[i]  = tbl_val[i];
			prev_hash[i] = tbl_hash[i];
			tbl_used[i]  = 1'b0;
		end
		tbl_size = grown_size;
		// Re-place live entries in old slot order.
		for (int unsigned i = 0; i < old_size; i++) begin
			if (prev_used[i] && walk_chain(prev_key[i], prev_hash[i], at) >= 0) begin
				tbl_used[at] = 1'b1;
				tbl_key[at]  = prev_key[i];
				tbl_val[at]  = prev_val[i];
				tbl_hash[at] = prev_hash[i];
			end
		end
	endfunction

	function automatic rsp_t predict_table_op(input req_t r);
		rsp_t        o;
		int          hit;
		int unsigned at;
		o = '0;
		hit = walk_chain(r.key, r.key_hash, at);
		if (r.func == FUNC_LOOKUP) begin
			if (hit == 1) begin
				o.status = ST_FOUND;
				o.found_value = tbl_val[at];
			end else begin
				o.status = ST_MISSING;
				at = 0;
			end
		end else if (hit == 1) begin
			o.status = ST_UPDATED;
			if (!keep_existing) tbl_val[at] = r.value;
		end else if (hit == 0) begin
			o.status = ST_INSERTED;
			tbl_used[at] = 1'b1;
			tbl_key[at]  = r.key;
			tbl_val[at]  = r.value;
			tbl_hash[at] = r.key_hash;
			tbl_count++;
			// Grow when fewer than a quarter of the slots (at least one) stay free.
			if (tbl_size - tbl_count < ((tbl_size / 4 < 1) ? 1 : tbl_size / 4)) begin
				grow_table();
				void'(walk_chain(r.key, r.key_hash, at));
			end
		end else begin
			o.status = ST_FULL;
			at = 0;
		end
		o.slot_index = at[9:0];
		o.entry_count = tbl_count[10:0];
		return o;
	endfunction

	// Called at a rising edge; returns at the edge where the request transfers.
	// Start stays high so a following request can go out back to back.
	task automatic send_op(input func_t f, input logic [31:0] k, input logic [31:0] h,
			input logic [31:0] v);
		req_t r;
		r.func = f;
		r.key = k;
		r.key_hash = h;
		r.value = v;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(negedge clk); while (busy);
		@(posedge clk);
		pending_rsp.push_back(predict_table_op(r));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register once all pending results have come back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d[CFG_DATA_W-1:0];
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_CAPACITY) begin
			cap_reg = d & 32'h7FF;
			clear_table();
		end else if (idx == REG_SET_MODE) begin
			keep_existing = d[0];
		end
	endtask

	// Compare each result with the oldest prediction; done lasts one cycle.
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				want = pending_rsp.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						result.status, want.status));
				if (result.found_value !== want.found_value)
					report_mismatch($sformatf("found_value %h, want %h",
						result.found_value, want.found_value));
				if (result.slot_index !== want.slot_index)
					report_mismatch($sformatf("slot_index %0d, want %0d",
						result.slot_index, want.slot_index));
				if (result.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						result.entry_count, want.entry_count));
			end
		end
	end

	// Reset table: misses, extreme keys and values, update, set mode, collisions, growth.
	task automatic test_basic_ops();
		send_op(FUNC_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_op(FUNC_PUT, 32'h0, 32'h0, 32'h0);
		send_op(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FUNC_PUT, 32'h0, 32'h0, 32'hA5A5_5A5A);
		send_op(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0);
		send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		write_reg(REG_SET_MODE, 1);
		send_op(FUNC_PUT, 32'h0, 32'h0, 32'h1234_5678);
		send_op(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0);
		write_reg(REG_SET_MODE, 0);
		// Same hash: collisions chain upward, then the fifth entry forces growth.
		send_op(FUNC_PUT, 32'h11, 32'h3, 32'h1);
		send_op(FUNC_PUT, 32'h22, 32'h3, 32'h2);
		send_op(FUNC_PUT, 32'h33, 32'h3, 32'h3);
		send_op(FUNC_LOOKUP, 32'h33, 32'h3, 32'h0);
		send_op(FUNC_LOOKUP, 32'h44, 32'h3, 32'h0);
		// Ignored register index, table must keep its contents.
		write_reg(REG_NONE, 12'h7FF);
		send_op(FUNC_LOOKUP, 32'h22, 32'h3, 32'h0);
	endtask

	// Capacity zero, above the cap and a capacity of one.
	task automatic test_capacity_limits();
		write_reg(REG_CAPACITY, 0);
		send_op(FUNC_PUT, 32'h5555_AAAA, 32'h8000_0000, 32'h1);
		send_op(FUNC_PUT, 32'hAAAA_5555, 32'h7FFF_FFFF, 32'h2);
		send_op(FUNC_LOOKUP, 32'h5555_AAAA, 32'h8000_0000, 32'h0);
		write_reg(REG_CAPACITY, 2047);
		send_op(FUNC_LOOKUP, 32'h5555_AAAA, 32'h8000_0000, 32'h0);
		send_op(FUNC_PUT, 32'h1, 32'hFFFF_FFFF, 32'h7);
		write_reg(REG_CAPACITY, 1);
		send_op(FUNC_PUT, 32'h2, 32'h0, 32'h9);
		// Hold off until the block has answered everything.
		drain_results();
	endtask

	// Phases with fresh capacity and mode, keys mostly drawn from a pool.
	task automatic test_random_traffic(input int phases, input int per_phase);
		int unsigned caps[7] = '{1, 2, 3, 5, 7, 16, 100};
		int p;
		for (int ph = 0; ph < phases; ph++) begin
			write_reg(REG_CAPACITY, caps[$urandom_range(0, 6)]);
			write_reg(REG_SET_MODE, $urandom_range(0, 1));
			for (int i = 0; i < 64; i++) begin
				key_pool[i] = $urandom();
				hash_pool[i] = $urandom();
			end
			for (int i = 0; i < per_phase; i++) begin
				p = $urandom_range(0, 63);
				if ($urandom_range(0, 9) == 0)
					send_op(func_t'($urandom_range(0, 1)), $urandom(), $urandom(),
						$urandom());
				else
					send_op(func_t'($urandom_range(0, 1)), key_pool[p], hash_pool[p],
						$urandom());
			end
		end
	endtask

	initial begin
		cap_reg = DEFAULT_CAP;
		keep_existing = 1'b0;
		clear_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_limits();
		test_random_traffic(5, 110);
		// Last stretch runs without gaps.
		no_gaps = 1'b1;
		test_random_traffic(1, 120);
		drain_results();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/lpht_pkg.sv
design/linear_probe_hash_table_core.sv
design/lpht_checker.sv
bench/tb_top.sv
